>>> hw/rtl/tcc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tcc_pkg
// Shared sizes, character codes, register indexes and control types for the
// text console cursor/scroll engine.
// ============================================================================
package tcc_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int CELL_IDX_W = $clog2(CELL_COUNT);

    // Word field widths
    localparam int OPER_W = 2;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 1;

    // Tab stops every eight columns
    localparam int TAB_STOP = 8;

    // Register reset values
    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'd15;
    localparam logic [CELL_W-1:0] BLANK_RESET = 16'd3872;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

    // Operation codes
    typedef enum logic [OPER_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Controller states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_FILL,
        S_WIPE,
        S_DONE
    } t_state;

    // Sweep write source for the cell memory
    typedef enum logic [1:0] {
        WR_NONE,
        WR_COPY,
        WR_BLANK,
        WR_INIT
    } t_wmode;

    // Controller to datapath
    typedef struct packed {
        logic   in_ready;
        logic   cnt_clr;
        logic   cnt_inc;
        t_wmode wr_mode;
        logic   rd_copy;
        logic   capture;
        logic   out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        t_op  op;
        logic need_scroll;
        logic copy_end;
        logic cell_last;
        logic out_free;
    } t_status;

    // Linear cell index of a row/column pair
    function automatic logic [CELL_IDX_W-1:0] lin_pos(input logic [ROW_W-1:0] row,
                                                      input logic [COL_W-1:0] col);
        return CELL_IDX_W'(int'(row) * COLUMNS + int'(col));
    endfunction

endpackage

>>> hw/rtl/tcc_cmd_if.sv
`timescale 1ns / 1ps
// ============================================================================
// tcc_cmd_if
// Input channel of the console engine: one operation word per handshake.
// ============================================================================
interface tcc_cmd_if import tcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OPER_W-1:0] operation;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;

    modport source (output valid, output operation, output char_code,
                    output cell_address, input ready);
    modport sink   (input valid, input operation, input char_code,
                    input cell_address, output ready);
endinterface

>>> hw/rtl/tcc_rsp_if.sv
`timescale 1ns / 1ps
// ============================================================================
// tcc_rsp_if
// Result channel of the console engine: one result word per handshake.
// ============================================================================
interface tcc_rsp_if import tcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] cursor_position;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;

    modport source (output valid, output cursor_position, output cell_value,
                    output scrolled, input ready);
    modport sink   (input valid, input cursor_position, input cell_value,
                    input scrolled, output ready);
endinterface

>>> hw/rtl/tcc_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// tcc_ctrl
// Sequencer of the console engine: accepts words, runs memory sweeps for
// power-up blanking, clear and scroll, and hands results to the output stage.
// ============================================================================
module tcc_ctrl import tcc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_status.in_valid && (r_state == S_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_status.cell_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_status.op)
                        OP_PUT:   n_state = i_status.need_scroll ? S_SCROLL : S_DONE;
                        OP_CLEAR: n_state = S_WIPE;
                        OP_READ:  n_state = S_READ;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_SCROLL: begin
                if (i_status.copy_end) n_state = S_FILL;
            end
            S_FILL, S_WIPE: begin
                if (i_status.cell_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '{in_ready: 1'b0, cnt_clr: 1'b0, cnt_inc: 1'b0, wr_mode: WR_NONE,
                  rd_copy: 1'b0, capture: 1'b0, out_load: 1'b0};
        case (r_state)
            S_INIT: begin
                o_cmd.wr_mode = WR_INIT;
                o_cmd.cnt_inc = 1'b1;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.cnt_clr  = accept;
            end
            S_READ: begin
                o_cmd.capture = 1'b1;
            end
            S_SCROLL: begin
                o_cmd.wr_mode = WR_COPY;
                o_cmd.rd_copy = 1'b1;
                // hold the count at the end so the fill starts on the bottom row
                o_cmd.cnt_inc = !i_status.copy_end;
            end
            S_FILL, S_WIPE: begin
                o_cmd.wr_mode = WR_BLANK;
                o_cmd.cnt_inc = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule

>>> hw/rtl/tcc_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// tcc_datapath
// Cursor, configuration registers, cell memory with sweep counter, and the
// output register of the console engine.
// ============================================================================
module tcc_datapath import tcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tcc_cmd_if.sink          i_cmd,
    tcc_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_cmd             i_ctl,
    output t_status          o_status
);

    // Registers
    logic [ATTR_W-1:0]     r_attr;
    logic [CELL_W-1:0]     r_blank;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic [CELL_IDX_W-1:0] r_cnt;
    logic [CELL_W-1:0]     r_cells [CELL_COUNT];
    logic [CELL_W-1:0]     r_rdata;
    logic                  r_addr_ok;
    logic [CELL_W-1:0]     r_cell;
    logic                  r_scrolled;
    logic                  r_out_valid;
    logic [ADDR_W-1:0]     r_out_pos;
    logic [CELL_W-1:0]     r_out_cell;
    logic                  r_out_scr;

    // Next values and local logic
    logic [COL_W:0]        n_col;
    logic [ROW_W:0]        n_row;
    logic                  accept;
    logic                  printable;
    logic                  need_scroll;
    logic                  put_en;
    logic                  wr_en;
    logic [CELL_IDX_W-1:0] wr_idx;
    logic [CELL_W-1:0]     wr_data;
    logic [CELL_IDX_W-1:0] rd_idx;
    t_op                   op;

    assign op     = t_op'(i_cmd.operation);
    assign accept = i_cmd.valid && i_ctl.in_ready;
    assign i_cmd.ready = i_ctl.in_ready;

    assign printable = (i_cmd.char_code >= CH_SPACE) && (i_cmd.char_code <= CH_DEL);

    // Work out the cursor after a put-character word
    always_comb begin
        n_col = {1'b0, r_col};
        n_row = {1'b0, r_row};
        if (i_cmd.char_code == CH_BS && r_col != '0) begin
            n_col = n_col - 1'b1;
        end else if (i_cmd.char_code == CH_TAB) begin
            n_col = (n_col + (COL_W+1)'(TAB_STOP)) & ~((COL_W+1)'(TAB_STOP - 1));
        end else if (i_cmd.char_code == CH_CR) begin
            n_col = '0;
        end else if (i_cmd.char_code == CH_LF) begin
            n_col = '0;
            n_row = n_row + 1'b1;
        end else if (printable) begin
            n_col = n_col + 1'b1;
        end
        // wrap past the right edge
        if (n_col >= (COL_W+1)'(COLUMNS)) begin
            n_col = '0;
            n_row = n_row + 1'b1;
        end
    end

    assign need_scroll = (n_row >= (ROW_W+1)'(ROWS));
    assign put_en      = accept && (op == OP_PUT) && printable;

    // Status back to the sequencer
    assign o_status.in_valid    = i_cmd.valid;
    assign o_status.op          = op;
    assign o_status.need_scroll = need_scroll;
    assign o_status.copy_end    = (r_cnt == CELL_IDX_W'(COPY_COUNT));
    assign o_status.cell_last   = (r_cnt == CELL_IDX_W'(CELL_COUNT - 1));
    assign o_status.out_free    = !r_out_valid || o_rsp.ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr  <= ATTR_RESET;
            r_blank <= BLANK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ATTR:  r_attr  <= i_cfg_data[ATTR_W-1:0];
                CFG_BLANK: r_blank <= i_cfg_data[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // Cursor update at accept; a scroll parks the cursor on the bottom row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            case (op)
                OP_PUT: begin
                    r_col <= n_col[COL_W-1:0];
                    r_row <= need_scroll ? ROW_W'(ROWS - 1) : n_row[ROW_W-1:0];
                end
                OP_CLEAR: begin
                    r_col <= '0;
                    r_row <= '0;
                end
                default: ;
            endcase
        end
    end

    // Sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_ctl.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Select the memory write source
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_cnt;
        wr_data = r_blank;
        if (put_en) begin
            wr_en   = 1'b1;
            wr_idx  = lin_pos(r_row, r_col);
            wr_data = {r_attr, i_cmd.char_code};
        end else begin
            case (i_ctl.wr_mode)
                WR_COPY: begin
                    // data from the registered read lands one row up
                    wr_en   = (r_cnt != '0);
                    wr_idx  = r_cnt - 1'b1;
                    wr_data = r_rdata;
                end
                WR_BLANK: begin
                    wr_en   = 1'b1;
                    wr_data = r_blank;
                end
                WR_INIT: begin
                    wr_en   = 1'b1;
                    wr_data = BLANK_RESET;
                end
                default: ;
            endcase
        end
    end

    // Select the memory read address
    always_comb begin
        if (i_ctl.rd_copy) begin
            rd_idx = (r_cnt < CELL_IDX_W'(COPY_COUNT))
                   ? CELL_IDX_W'(int'(r_cnt) + COLUMNS) : '0;
        end else begin
            rd_idx = CELL_IDX_W'(i_cmd.cell_address);
        end
    end

    // Cell memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cells[wr_idx] <= wr_data;
        end
        r_rdata <= r_cells[rd_idx];
    end

    // Per-word result fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr_ok  <= (int'(i_cmd.cell_address) < CELL_COUNT);
            r_cell     <= '0;
            r_scrolled <= (op == OP_PUT) && need_scroll;
        end else if (i_ctl.capture) begin
            r_cell <= r_addr_ok ? r_rdata : '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_pos  <= ADDR_W'(lin_pos(r_row, r_col));
            r_out_cell <= r_cell;
            r_out_scr  <= r_scrolled;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.cursor_position = r_out_pos;
    assign o_rsp.cell_value      = r_out_cell;
    assign o_rsp.scrolled        = r_out_scr;

    // Checks
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_load |-> (!r_out_valid || o_rsp.ready))
        else $error("result loaded over an untaken word");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_col) < COLUMNS) && (int'(r_row) < ROWS))
        else $error("cursor outside the screen");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && op == OP_PUT && need_scroll) |=> (r_row == ROW_W'(ROWS - 1)))
        else $error("scroll did not park the cursor on the bottom row");

    a_put_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        put_en |-> (i_ctl.wr_mode == WR_NONE))
        else $error("character write collides with a memory sweep");

endmodule

>>> hw/rtl/text_console_cursor_scroll.sv
`timescale 1ns / 1ps
// ============================================================================
// text_console_cursor_scroll
// Text-mode console engine: 80x25 screen of 16-bit cells with cursor,
// control-code handling, wrap, scroll, clear and cell read-back.
// ============================================================================
// One word is taken at a time. A put-character word without scroll and an
// unused operation code go straight to the result; a read first captures
// the cell. Scroll and clear walk the single-write-port cell memory: scroll
// copies ROWS-1 rows with one cell per cycle through the registered read,
// then blanks the bottom row; clear blanks every cell. After reset a blanking
// pass runs before the first word is taken; configuration writes are taken
// during it. A finished result waits in an output register, and the next word
// is accepted while it waits.
module text_console_cursor_scroll import tcc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tcc_cmd_if.sink              i_cmd,
    tcc_rsp_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd    ctl;
    t_status status;

    // Sequencer
    tcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (ctl)
    );

    // Cursor, memory and output stage
    tcc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (ctl),
        .o_status    (status)
    );

endmodule

>>> tb/tcc_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tcc_scoreboard_pkg
// Screen model and result checking for the text console engine bench. The
// class keeps its own copy of the screen, the cursor and both registers,
// works out the result word of every accepted operation word, and compares
// the words coming back from the engine, field by field, in order.
// ============================================================================
package tcc_scoreboard_pkg;
    import tcc_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] cursor_position;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } console_result_t;

    class console_scoreboard;
        logic [CELL_W-1:0] screen [CELL_COUNT];
        int unsigned       col;
        int unsigned       row;
        logic [ATTR_W-1:0] attr;
        logic [CELL_W-1:0] blank;
        console_result_t   due_q [$];
        int unsigned       errors;

        // Start from the reset screen: every cell blank, cursor home
        function new();
            attr   = ATTR_RESET;
            blank  = BLANK_RESET;
            col    = 0;
            row    = 0;
            errors = 0;
            foreach (screen[i]) screen[i] = BLANK_RESET;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_ATTR:  attr  = data[ATTR_W-1:0];
                CFG_BLANK: blank = data[CELL_W-1:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted operation word and queue the result it must give
        function void note_word(t_op op, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] addr);
            console_result_t due;
            due = '0;
            case (op)
                OP_PUT: begin
                    if (ch == CH_BS) begin
                        if (col != 0) col--;
                    end else if (ch == CH_TAB) begin
                        col = (col + TAB_STOP) & ~(TAB_STOP - 1);
                    end else if (ch == CH_CR) begin
                        col = 0;
                    end else if (ch == CH_LF) begin
                        col = 0;
                        row++;
                    end else if (ch >= CH_SPACE && ch <= CH_DEL) begin
                        screen[row * COLUMNS + col] = {attr, ch};
                        col++;
                    end
                    // wrap at the right edge
                    if (col >= COLUMNS) begin
                        col = 0;
                        row++;
                    end
                    // scroll up one row past the bottom
                    if (row >= ROWS) begin
                        for (int i = 0; i < COPY_COUNT; i++) screen[i] = screen[i + COLUMNS];
                        for (int i = COPY_COUNT; i < CELL_COUNT; i++) screen[i] = blank;
                        row = ROWS - 1;
                        due.scrolled = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    foreach (screen[i]) screen[i] = blank;
                    col = 0;
                    row = 0;
                end
                OP_READ: begin
                    if (addr < CELL_COUNT) due.cell_value = screen[addr];
                end
                default: ;
            endcase
            due.cursor_position = ADDR_W'(row * COLUMNS + col);
            due_q.push_back(due);
        endfunction

        function void check_result(logic [ADDR_W-1:0] pos, logic [CELL_W-1:0] cell_val,
                                   logic scr);
            console_result_t due;
            if (due_q.size() == 0) begin
                $error("result word with none expected: pos %0d cell %h scrolled %b",
                       pos, cell_val, scr);
                errors++;
                return;
            end
            due = due_q.pop_front();
            if (pos !== due.cursor_position) begin
                $error("cursor_position: expected %0d, got %0d", due.cursor_position, pos);
                errors++;
            end
            if (cell_val !== due.cell_value) begin
                $error("cell_value: expected %h, got %h", due.cell_value, cell_val);
                errors++;
            end
            if (scr !== due.scrolled) begin
                $error("scrolled: expected %b, got %b", due.scrolled, scr);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction
    endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Bench for the text console engine: a short directed run over control codes,
// ignored bytes, tab wrap and out-of-range reads, then random operation
// words in phases with different register settings and line-feed density,
// with random gaps on the input side and random stalls on the result side.
// ============================================================================
module tb_top;
    import tcc_pkg::*;
    import tcc_scoreboard_pkg::*;

    localparam int PHASES       = 5;
    localparam int PHASE_WORDS  = 190;
    localparam int STALL_LIMIT  = 10000;
    localparam int LF_PCT [PHASES] = '{3, 30, 10, 0, 15};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 calm;
    int unsigned          quiet_cycles;

    console_scoreboard sb = new();

    tcc_cmd_if cmd ();
    tcc_rsp_if rsp ();

    text_console_cursor_scroll DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_rsp       (rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stall the result side at random, except in calm stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
        end else begin
            rsp.ready <= calm || ($urandom_range(99) >= 7);
            if (rsp.valid && rsp.ready)
                sb.check_result(rsp.cursor_position, rsp.cell_value, rsp.scrolled);
        end
    end

    // Give up when no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Offer one operation word, with an occasional gap ahead of it
    task automatic drive_word(input t_op op, input logic [CHAR_W-1:0] ch,
                              input logic [ADDR_W-1:0] addr);
        int gap;
        if (!calm && $urandom_range(99) < 7) begin
            gap = $urandom_range(1, 4);
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd.valid        <= 1'b1;
        cmd.operation    <= op;
        cmd.char_code    <= ch;
        cmd.cell_address <= addr;
        do @(posedge i_clk); while (!cmd.ready);
        sb.note_word(op, ch, addr);
    endtask

    // Drop valid and wait until every result word is back
    task automatic drain();
        cmd.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write both registers back to back while the engine is idle
    task automatic set_config(input logic [ATTR_W-1:0] attr, input logic [CELL_W-1:0] blank);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ATTR;
        i_cfg_data  <= CFG_W'(attr);
        @(posedge i_clk);
        sb.write_reg(CFG_ATTR, CFG_W'(attr));
        i_cfg_index <= CFG_BLANK;
        i_cfg_data  <= blank;
        @(posedge i_clk);
        sb.write_reg(CFG_BLANK, blank);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly printable text, with control codes, noise bytes, reads, clears and unused operation codes
    function automatic void random_word(input int lf_pct, output t_op op,
                                        output logic [CHAR_W-1:0] ch,
                                        output logic [ADDR_W-1:0] addr);
        int pick;
        int sort;
        pick = $urandom_range(999);
        sort = $urandom_range(99);
        ch   = CHAR_W'($urandom);
        addr = ($urandom_range(9) == 0) ? ADDR_W'($urandom)
                                        : ADDR_W'($urandom_range(CELL_COUNT - 1));
        if (pick < 5)
            op = OP_CLEAR;
        else if (pick < 105)
            op = OP_READ;
        else if (pick < 120)
            op = OP_NONE;
        else begin
            op = OP_PUT;
            if (sort < lf_pct)
                ch = CH_LF;
            else if (sort < lf_pct + 4)
                ch = CH_CR;
            else if (sort < lf_pct + 8)
                ch = CH_TAB;
            else if (sort < lf_pct + 12)
                ch = CH_BS;
            else if (sort >= lf_pct + 18)
                ch = CHAR_W'($urandom_range(CH_SPACE, CH_DEL));
        end
    endfunction

    initial begin
        t_op               op;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;

        calm             <= 1'b0;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= CFG_ATTR;
        i_cfg_data       <= '0;
        cmd.valid        <= 1'b0;
        cmd.operation    <= OP_NONE;
        cmd.char_code    <= '0;
        cmd.cell_address <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset screen, out-of-range read, unused operation code
        drive_word(OP_READ, 8'h00, 11'd0);
        drive_word(OP_READ, 8'h00, ADDR_W'(CELL_COUNT - 1));
        drive_word(OP_READ, 8'h00, ADDR_W'(CELL_COUNT));
        drive_word(OP_NONE, 8'hFF, 11'h7FF);
        // Printable bounds, ignored bytes, backspace, return
        drive_word(OP_PUT, CH_SPACE, 11'd0);
        drive_word(OP_PUT, CH_DEL, 11'd0);
        drive_word(OP_PUT, 8'h80, 11'd0);
        drive_word(OP_PUT, 8'hFF, 11'd0);
        drive_word(OP_PUT, 8'h1F, 11'd0);
        drive_word(OP_PUT, CH_BS, 11'd0);
        drive_word(OP_PUT, CH_CR, 11'd0);
        drive_word(OP_PUT, CH_BS, 11'd0);
        // Tab across the row until it wraps, then a line feed and a clear
        repeat (10) drive_word(OP_PUT, CH_TAB, 11'd0);
        drive_word(OP_PUT, CH_LF, 11'd0);
        drive_word(OP_CLEAR, 8'h00, 11'd0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: ;
                1: set_config(8'h00, 16'h0000);
                2: set_config(8'hFF, 16'hFFFF);
                default: set_config(ATTR_W'($urandom), CELL_W'($urandom));
            endcase
            calm <= (ph == 3);
            repeat (PHASE_WORDS) begin
                random_word(LF_PCT[ph], op, ch, addr);
                drive_word(op, ch, addr);
            end
            drain();
        end

        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
